[design/svg_path_command_normalizer_unit_assert.svh]
// ----------------------------------------------------------------------------
// SVG path normalizer assertion macros
// Clocked assertion wrappers shared by the normalizer RTL.
// ----------------------------------------------------------------------------
`ifndef SVG_PATH_COMMAND_NORMALIZER_UNIT_ASSERT_SVH
`define SVG_PATH_COMMAND_NORMALIZER_UNIT_ASSERT_SVH

// check on every rising edge outside reset
`define SVGPN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// check on every rising edge, reset included
`define SVGPN_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[design/svgpn_pkg.sv]
// ----------------------------------------------------------------------------
// SVG path normalizer package
// Command and emit codes, field widths and saturating Q16.16 helpers.
// ----------------------------------------------------------------------------
package svgpn_pkg;

    localparam int COORD_W   = 32;
    localparam int NUM_PARAM = 7;
    localparam int MODE_W    = 4;
    localparam int CNT_W     = 3;
    localparam int KIND_W    = 3;
    localparam int IN_USER_W = MODE_W + 2 + CNT_W;
    localparam int IN_DATA_W = NUM_PARAM * COORD_W;
    localparam int OUT_DATA_W = 6 * COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int WIDE_W    = COORD_W + 3;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = DIFF_W + FRAC_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic [MODE_W-1:0]         t_mode;
    typedef logic [CNT_W-1:0]          t_cnt;
    typedef logic [KIND_W-1:0]         t_kind;

    localparam t_mode MODE_MOVE   = 4'd0;
    localparam t_mode MODE_LINE   = 4'd1;
    localparam t_mode MODE_HORIZ  = 4'd2;
    localparam t_mode MODE_VERT   = 4'd3;
    localparam t_mode MODE_CUBIC  = 4'd4;
    localparam t_mode MODE_SMOOTH = 4'd5;
    localparam t_mode MODE_QUAD   = 4'd6;
    localparam t_mode MODE_ARC    = 4'd7;
    localparam t_mode MODE_CLOSE  = 4'd8;

    localparam t_kind EMIT_NONE  = 3'd0;
    localparam t_kind EMIT_MOVE  = 3'd1;
    localparam t_kind EMIT_LINE  = 3'd2;
    localparam t_kind EMIT_CUBIC = 3'd3;
    localparam t_kind EMIT_CLOSE = 3'd4;

    localparam t_cnt NEED_AXIS  = 3'd1;
    localparam t_cnt NEED_POINT = 3'd2;
    localparam t_cnt NEED_QUAD  = 3'd4;
    localparam t_cnt NEED_CUBIC = 3'd6;
    localparam t_cnt NEED_ARC   = 3'd7;

    localparam logic [FRAC_W-1:0] TWO_THIRDS_Q16 = 16'hAAAB;

    localparam t_wide SAT_HI = t_wide'(2147483647);
    localparam t_wide SAT_LO = -t_wide'(64'sd2147483648);

    function automatic t_coord sat_wide(input t_wide v);
        if (v > SAT_HI) begin
            return t_coord'(SAT_HI);
        end else if (v < SAT_LO) begin
            return t_coord'(SAT_LO);
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic t_coord coord(input logic rel, input t_coord base, input t_coord p);
        if (rel) begin
            return sat_wide(t_wide'(base) + t_wide'(p));
        end
        return p;
    endfunction

    function automatic t_coord reflect(input t_coord pen, input t_coord last);
        return sat_wide(t_wide'(pen) + t_wide'(pen) - t_wide'(last));
    endfunction

    // base + floor(d * 16'hAAAB / 2^16), about d * 2/3; floor taken by the arithmetic shift
    function automatic t_coord raise23(input t_coord base, input t_diff d);
        logic signed [PROD_W-1:0]        prod;
        logic signed [PROD_W-FRAC_W-1:0] scaled;
        prod   = PROD_W'(d) * PROD_W'($signed({1'b0, TWO_THIRDS_Q16}));
        scaled = prod[PROD_W-1:FRAC_W];
        return sat_wide(t_wide'(base) + t_wide'(scaled));
    endfunction

endpackage

[design/svg_path_command_normalizer_unit.sv]
// ----------------------------------------------------------------------------
// SVG path command normalizer
// Turns one path command per item into an absolute move, line, cubic, close or none.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser
// s_axis   in   param_a..param_g (32 b each)   mode, relative, path_start, param_count
// m_axis   out  ctrl1_x..end_y (32 b each)     emit_kind
//
// One result item per input item.
// One item per cycle unless m_axis stalls; the pen/subpath/control registers
// update in the command stage, so a command sees the state of the one before it.
// A stall on m_axis holds all three stages and drops s_axis_tready.
// Reset clears the stage valids and the pen, subpath and control point.
// ----------------------------------------------------------------------------
`include "svg_path_command_normalizer_unit_assert.svh"

module svg_path_command_normalizer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // param_a, param_b, param_c, param_d, param_e, param_f, param_g
    input  logic [svgpn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode[3:0], relative, path_start, param_count[2:0]
    input  logic [svgpn_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
    output logic [svgpn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // emit_kind[2:0]
    output logic [svgpn_pkg::KIND_W-1:0]     m_axis_tuser
);
    import svgpn_pkg::*;

    logic   en;

    logic   r_in_valid;
    t_mode  r_in_mode;
    logic   r_in_rel;
    logic   r_in_start;
    t_cnt   r_in_cnt;
    t_coord r_in_p [NUM_PARAM];

    t_coord r_pen_x, r_pen_y, r_sub_x, r_sub_y, r_last_x, r_last_y;
    t_coord n_pen_x, n_pen_y, n_sub_x, n_sub_y, n_last_x, n_last_y;

    logic   r_mid_valid;
    t_kind  r_mid_kind, n_mid_kind;
    logic   r_mid_quad, n_mid_quad;
    t_coord r_mid_c1x, r_mid_c1y, r_mid_c2x, r_mid_c2y, r_mid_ex, r_mid_ey;
    t_coord n_mid_c1x, n_mid_c1y, n_mid_c2x, n_mid_c2y, n_mid_ex, n_mid_ey;
    t_diff  r_mid_d1x, r_mid_d1y, r_mid_d2x, r_mid_d2y;
    t_diff  n_mid_d1x, n_mid_d1y, n_mid_d2x, n_mid_d2y;

    logic   r_out_valid;
    t_kind  r_out_kind;
    t_coord r_out_c1x, r_out_c1y, r_out_c2x, r_out_c2y, r_out_ex, r_out_ey;
    t_coord n_out_c1x, n_out_c1y, n_out_c2x, n_out_c2y;

    t_coord pen_x0, pen_y0, sub_x0, sub_y0, last_x0, last_y0;
    t_coord xa, xc, xe, xf, ya, yb, yd, yf, yg;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (en) begin
            r_in_mode  <= s_axis_tuser[MODE_W-1:0];
            r_in_rel   <= s_axis_tuser[MODE_W];
            r_in_start <= s_axis_tuser[MODE_W+1];
            r_in_cnt   <= s_axis_tuser[MODE_W+2 +: CNT_W];
            for (int i = 0; i < NUM_PARAM; i++) begin
                r_in_p[i] <= s_axis_tdata[i*COORD_W +: COORD_W];
            end
        end
    end

    // command stage
    always_comb begin
        pen_x0  = r_in_start ? '0 : r_pen_x;
        pen_y0  = r_in_start ? '0 : r_pen_y;
        sub_x0  = r_in_start ? '0 : r_sub_x;
        sub_y0  = r_in_start ? '0 : r_sub_y;
        last_x0 = r_in_start ? '0 : r_last_x;
        last_y0 = r_in_start ? '0 : r_last_y;

        xa = coord(r_in_rel, pen_x0, r_in_p[0]);
        xc = coord(r_in_rel, pen_x0, r_in_p[2]);
        xe = coord(r_in_rel, pen_x0, r_in_p[4]);
        xf = coord(r_in_rel, pen_x0, r_in_p[5]);
        ya = coord(r_in_rel, pen_y0, r_in_p[0]);
        yb = coord(r_in_rel, pen_y0, r_in_p[1]);
        yd = coord(r_in_rel, pen_y0, r_in_p[3]);
        yf = coord(r_in_rel, pen_y0, r_in_p[5]);
        yg = coord(r_in_rel, pen_y0, r_in_p[6]);

        n_pen_x  = pen_x0;
        n_pen_y  = pen_y0;
        n_sub_x  = sub_x0;
        n_sub_y  = sub_y0;
        n_last_x = last_x0;
        n_last_y = last_y0;

        n_mid_kind = EMIT_NONE;
        n_mid_quad = 1'b0;
        n_mid_c1x  = '0;
        n_mid_c1y  = '0;
        n_mid_c2x  = '0;
        n_mid_c2y  = '0;
        n_mid_ex   = '0;
        n_mid_ey   = '0;
        n_mid_d1x  = '0;
        n_mid_d1y  = '0;
        n_mid_d2x  = '0;
        n_mid_d2y  = '0;

        unique case (r_in_mode)
            MODE_MOVE, MODE_LINE: begin
                if (r_in_cnt >= NEED_POINT) begin
                    n_pen_x  = xa;
                    n_pen_y  = yb;
                    n_mid_ex = xa;
                    n_mid_ey = yb;
                    if (r_in_mode == MODE_MOVE) begin
                        n_sub_x    = xa;
                        n_sub_y    = yb;
                        n_mid_kind = EMIT_MOVE;
                    end else begin
                        n_mid_kind = EMIT_LINE;
                    end
                end
            end
            MODE_HORIZ: begin
                if (r_in_cnt >= NEED_AXIS) begin
                    n_pen_x    = xa;
                    n_mid_ex   = xa;
                    n_mid_ey   = pen_y0;
                    n_mid_kind = EMIT_LINE;
                end
            end
            MODE_VERT: begin
                if (r_in_cnt >= NEED_AXIS) begin
                    n_pen_y    = ya;
                    n_mid_ex   = pen_x0;
                    n_mid_ey   = ya;
                    n_mid_kind = EMIT_LINE;
                end
            end
            MODE_CUBIC: begin
                if (r_in_cnt >= NEED_CUBIC) begin
                    n_mid_c1x  = xa;
                    n_mid_c1y  = yb;
                    n_mid_c2x  = xc;
                    n_mid_c2y  = yd;
                    n_mid_ex   = xe;
                    n_mid_ey   = yf;
                    n_last_x   = xc;
                    n_last_y   = yd;
                    n_pen_x    = xe;
                    n_pen_y    = yf;
                    n_mid_kind = EMIT_CUBIC;
                end
            end
            MODE_SMOOTH: begin
                if (r_in_cnt >= NEED_QUAD) begin
                    n_mid_c1x  = reflect(pen_x0, last_x0);
                    n_mid_c1y  = reflect(pen_y0, last_y0);
                    n_mid_c2x  = xa;
                    n_mid_c2y  = yb;
                    n_mid_ex   = xc;
                    n_mid_ey   = yd;
                    n_last_x   = xa;
                    n_last_y   = yb;
                    n_pen_x    = xc;
                    n_pen_y    = yd;
                    n_mid_kind = EMIT_CUBIC;
                end
            end
            MODE_QUAD: begin
                if (r_in_cnt >= NEED_QUAD) begin
                    n_mid_quad = 1'b1;
                    n_mid_c1x  = pen_x0;
                    n_mid_c1y  = pen_y0;
                    n_mid_d1x  = t_diff'(xa) - t_diff'(pen_x0);
                    n_mid_d1y  = t_diff'(yb) - t_diff'(pen_y0);
                    n_mid_d2x  = t_diff'(xa) - t_diff'(xc);
                    n_mid_d2y  = t_diff'(yb) - t_diff'(yd);
                    n_mid_ex   = xc;
                    n_mid_ey   = yd;
                    n_last_x   = xa;
                    n_last_y   = yb;
                    n_pen_x    = xc;
                    n_pen_y    = yd;
                    n_mid_kind = EMIT_CUBIC;
                end
            end
            MODE_ARC: begin
                if (r_in_cnt >= NEED_ARC) begin
                    n_pen_x    = xf;
                    n_pen_y    = yg;
                    n_mid_ex   = xf;
                    n_mid_ey   = yg;
                    n_mid_kind = EMIT_LINE;
                end
            end
            MODE_CLOSE: begin
                n_pen_x    = sub_x0;
                n_pen_y    = sub_y0;
                n_mid_ex   = sub_x0;
                n_mid_ey   = sub_y0;
                n_mid_kind = EMIT_CLOSE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_sub_x     <= '0;
            r_sub_y     <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
        end else if (en) begin
            r_mid_valid <= r_in_valid;
            if (r_in_valid) begin
                r_pen_x  <= n_pen_x;
                r_pen_y  <= n_pen_y;
                r_sub_x  <= n_sub_x;
                r_sub_y  <= n_sub_y;
                r_last_x <= n_last_x;
                r_last_y <= n_last_y;
            end
        end
        if (en) begin
            r_mid_kind <= n_mid_kind;
            r_mid_quad <= n_mid_quad;
            r_mid_c1x  <= n_mid_c1x;
            r_mid_c1y  <= n_mid_c1y;
            r_mid_c2x  <= n_mid_c2x;
            r_mid_c2y  <= n_mid_c2y;
            r_mid_ex   <= n_mid_ex;
            r_mid_ey   <= n_mid_ey;
            r_mid_d1x  <= n_mid_d1x;
            r_mid_d1y  <= n_mid_d1y;
            r_mid_d2x  <= n_mid_d2x;
            r_mid_d2y  <= n_mid_d2y;
        end
    end

    // raise stage
    always_comb begin
        if (r_mid_quad) begin
            n_out_c1x = raise23(r_mid_c1x, r_mid_d1x);
            n_out_c1y = raise23(r_mid_c1y, r_mid_d1y);
            n_out_c2x = raise23(r_mid_ex, r_mid_d2x);
            n_out_c2y = raise23(r_mid_ey, r_mid_d2y);
        end else begin
            n_out_c1x = r_mid_c1x;
            n_out_c1y = r_mid_c1y;
            n_out_c2x = r_mid_c2x;
            n_out_c2y = r_mid_c2y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_mid_valid;
        end
        if (en) begin
            r_out_kind <= r_mid_kind;
            r_out_c1x  <= n_out_c1x;
            r_out_c1y  <= n_out_c1y;
            r_out_c2x  <= n_out_c2x;
            r_out_c2y  <= n_out_c2y;
            r_out_ex   <= r_mid_ex;
            r_out_ey   <= r_mid_ey;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {r_out_ey, r_out_ex, r_out_c2y, r_out_c2x, r_out_c1y, r_out_c1x};

    `SVGPN_ASSERT(a_none_is_zero,
        m_axis_tvalid && m_axis_tuser == EMIT_NONE |-> m_axis_tdata == '0,
        "empty item carries data")
    `SVGPN_ASSERT(a_ctrl_cubic_only,
        m_axis_tvalid && m_axis_tuser != EMIT_CUBIC |-> m_axis_tdata[4*COORD_W-1:0] == '0,
        "control point on non-cubic")
    `SVGPN_ASSERT(a_stall_holds_state,
        !en |=> $stable(r_pen_x) && $stable(r_pen_y) && $stable(r_last_x),
        "state moved during stall")
    `SVGPN_ASSERT_ANY(a_reset_empties,
        !i_rst_n |=> !r_in_valid && !r_mid_valid && !r_out_valid,
        "stage valid after reset")

endmodule
